[design/hex_token_parser_macros.svh]
// ----------------------------------------------------------------------------
// hex_token_parser_macros: assertion macros
// Concurrent assertion wrappers shared by the hex token parser RTL.
// ----------------------------------------------------------------------------
`ifndef HEX_TOKEN_PARSER_MACROS_SVH
`define HEX_TOKEN_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hex_token_parser assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hex_token_parser assertion failed");

`endif

[design/htp_pkg.sv]
// ----------------------------------------------------------------------------
// htp_pkg
// Types and character constants for the hex token parser.
// ----------------------------------------------------------------------------
`default_nettype none

package htp_pkg;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LEAD   = 2'd1,
    PH_SIGNED = 2'd2,
    PH_DIGITS = 2'd3
  } phase_t;

  localparam logic [7:0]  CH_TAB    = 8'h09;
  localparam logic [7:0]  CH_SPACE  = 8'h20;
  localparam logic [7:0]  CH_COLON  = 8'h3A;
  localparam logic [7:0]  CH_PLUS   = 8'h2B;
  localparam logic [7:0]  CH_MINUS  = 8'h2D;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [7:0]  CH_NINE   = 8'h39;
  localparam logic [7:0]  CH_UC_A   = 8'h41;
  localparam logic [7:0]  CH_UC_F   = 8'h46;
  localparam logic [7:0]  CH_LC_A   = 8'h61;
  localparam logic [7:0]  CH_LC_F   = 8'h66;
  localparam logic [3:0]  NIB_TEN   = 4'd10;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

endpackage

`default_nettype wire

[design/hex_token_parser.sv]
// ----------------------------------------------------------------------------
// hex_token_parser
// Streaming hexadecimal token to 32-bit integer converter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one character per transaction,
//   with in_start_req marking the first character of a new conversion.
//   Leading space, tab and colon are skipped, one optional sign is taken,
//   then hex digits accumulate. The first character that cannot continue the
//   token ends it and produces one result transaction on the output channel
//   (out_value, out_failed, out_consumed); all other characters produce none.
//   Throughput: one character per cycle while no result is stalled. The parser
//   state update (one shift, add and compare) sits between the state
//   registers and is done in the cycle the character is accepted.
//   Output: the result appears at the output register in the cycle after
//   the terminating character is accepted.
//   Stall: while a result waits in the output register and out_ready is low,
//   in_ready is low; with out_ready high a new character is taken in the
//   same cycle the result leaves.
//   Reset: synchronous, active low; clears the parser to idle and empties
//   the output register. Characters are ignored until a start.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hex_token_parser_macros.svh"

module hex_token_parser
  import htp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_start_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_value,
  output logic             out_failed,
  output logic [15:0]      out_consumed
);

  phase_t      phase_r, phase_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic        ovf_r, ovf_nxt;
  logic        neg_r, neg_nxt;
  logic [15:0] count_r, count_nxt;

  logic        out_valid_r;
  logic [31:0] out_value_r, res_value;
  logic        out_failed_r, res_failed;
  logic [15:0] out_consumed_r, res_consumed;

  logic        in_fire;
  logic        emit;
  logic        is_digit;
  logic [3:0]  nibble;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Decode hex digit
  always_comb begin
    is_digit = 1'b1;
    nibble   = 4'd0;
    case (in_ch) inside
      [CH_ZERO:CH_NINE]: nibble = in_ch[3:0];
      [CH_UC_A:CH_UC_F]: nibble = NIB_TEN + (in_ch[3:0] - CH_UC_A[3:0]);
      [CH_LC_A:CH_LC_F]: nibble = NIB_TEN + (in_ch[3:0] - CH_LC_A[3:0]);
      default:           is_digit = 1'b0;
    endcase
  end

  always_comb begin
    phase_t      ph;
    logic [31:0] acc;
    logic        ovf;
    logic        neg;
    logic [15:0] cnt;
    logic [15:0] cnt_inc;

    ph  = phase_r;
    acc = accum_r;
    ovf = ovf_r;
    neg = neg_r;
    cnt = count_r;
    if (in_start_req) begin
      ph  = PH_LEAD;
      acc = '0;
      ovf = 1'b0;
      neg = 1'b0;
      cnt = '0;
    end
    cnt_inc = (cnt != COUNT_MAX) ? cnt + 16'd1 : cnt;

    emit         = 1'b0;
    res_value    = '0;
    res_failed   = 1'b1;
    res_consumed = '0;

    if (ph != PH_IDLE) begin
      if (is_digit) begin
        if (acc[31:28] != 4'd0) begin
          ovf = 1'b1;
        end else begin
          acc = {acc[27:0], nibble};
        end
        cnt = cnt_inc;
        ph  = PH_DIGITS;
      end else if (ph == PH_LEAD &&
                   (in_ch == CH_SPACE || in_ch == CH_TAB || in_ch == CH_COLON)) begin
        cnt = cnt_inc;
      end else if (ph == PH_LEAD && (in_ch == CH_PLUS || in_ch == CH_MINUS)) begin
        neg = (in_ch == CH_MINUS);
        cnt = cnt_inc;
        ph  = PH_SIGNED;
      end else begin
        // Terminator: report and drop back to idle
        emit = 1'b1;
        if (ph == PH_DIGITS) begin
          res_failed   = ovf;
          res_consumed = cnt;
          if (!ovf) begin
            res_value = neg ? (~acc + 32'd1) : acc;
          end
        end
        ph  = PH_IDLE;
        acc = '0;
        ovf = 1'b0;
        neg = 1'b0;
        cnt = '0;
      end
    end

    phase_nxt = ph;
    accum_nxt = acc;
    ovf_nxt   = ovf;
    neg_nxt   = neg;
    count_nxt = cnt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      accum_r <= '0;
      ovf_r   <= 1'b0;
      neg_r   <= 1'b0;
      count_r <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      ovf_r   <= ovf_nxt;
      neg_r   <= neg_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_value_r    <= res_value;
      out_failed_r   <= res_failed;
      out_consumed_r <= res_consumed;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_value    = out_value_r;
  assign out_failed   = out_failed_r;
  assign out_consumed = out_consumed_r;

  `HTP_ASSERT_NOW(a_stall_blocks_input, clk, rst_n, out_valid_r && !out_ready, !in_ready)
  `HTP_ASSERT_NOW(a_fail_zero_value, clk, rst_n, out_valid_r && out_failed_r, out_value_r == 32'd0)
  `HTP_ASSERT_NEXT(a_idle_ignores, clk, rst_n, in_fire && !in_start_req && phase_r == PH_IDLE, phase_r == PH_IDLE && count_r == 16'd0)
  `HTP_ASSERT_NEXT(a_emit_to_idle, clk, rst_n, in_fire && emit, out_valid_r && phase_r == PH_IDLE)

endmodule

`default_nettype wire
